// ===== hdl/ntsc_pkg.sv =====
// Shared types, constants and the month length table for the NTP seconds to calendar block.
package ntsc_pkg;

  // Default depth of the queue between the front and the back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Field types
  typedef logic [31:0] secs_t;
  typedef logic [11:0] year_t;

  // Time and calendar constants
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;
  localparam logic [16:0] ERA_SECS      = 17'd23296;
  localparam logic [16:0] ERA_DAYS      = 17'd49710;
  localparam logic [18:0] QUAD_DAYS     = 19'd1461;  // 365.25 days scaled by 256 is 64 * 1461
  localparam year_t       EPOCH_YEAR    = 12'd1900;
  localparam year_t       YEAR_BASE_RST = 12'd2000;
  localparam logic [3:0]  MONTHS        = 4'd12;

  // Reciprocals for division by a constant: x / d = (x * ceil(2^k / d)) >> k, exact over x's range
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // x = seconds >> 7, d = 675, k = 35
  localparam logic [13:0] HOUR_RECIP = 14'd9321;      // x = time of day >> 4, d = 225, k = 21
  localparam logic [10:0] MIN_RECIP  = 11'd1093;      // x = seconds in hour >> 2, d = 15, k = 14
  localparam logic [19:0] YEAR_RECIP = 20'd734937;    // x = 4 * (day number + 1), d = 1461, k = 30

  // One queued item: the seconds value and its era class
  typedef struct packed {
    logic  next_era;  // bit 31 clear: the value lies in the following era
    secs_t seconds;
  } job_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY,
    ST_TOD,
    ST_ERA,
    ST_HOUR,
    ST_MREM,
    ST_MIN,
    ST_SEC,
    ST_YEAR,
    ST_CHECK,
    ST_MONTH,
    ST_DONE
  } state_t;

  // Days in a zero-based month
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      4'd1: begin
        n = leap ? 5'd29 : 5'd28;
      end
      4'd3, 4'd5, 4'd8, 4'd10: begin
        n = 5'd30;
      end
      default: begin
        n = 5'd31;
      end
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/ntsc_if.sv =====
// Channel interfaces: seconds in, calendar fields out.
interface ntsc_in_if;
  logic               valid;
  logic               ready;
  ntsc_pkg::secs_t    ntp_seconds;

  modport source(output valid, output ntp_seconds, input ready);
  modport sink(input valid, input ntp_seconds, output ready);
endinterface

interface ntsc_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [7:0]  year_offset;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source(output valid, output valid_res, output year_offset, output month,
                 output day_of_month, output hour, output minute, output second,
                 input ready);
  modport sink(input valid, input valid_res, input year_offset, input month,
               input day_of_month, input hour, input minute, input second,
               output ready);
endinterface

// ===== hdl/ntsc_front.sv =====
// Front end: accepts items, tags the era and queues them for the back end.
module ntsc_front #(
  parameter int unsigned DEPTH = ntsc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ntsc_in_if.sink        in_ch,
  output ntsc_pkg::job_t job,
  output logic           job_valid,
  input  logic           job_pop
);
  import ntsc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          queue_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push;
  job_t          entry;

  // Handshake and era classification
  assign in_ch.ready    = (count_r != CW'(DEPTH));
  assign push           = in_ch.valid && in_ch.ready;
  assign entry.next_era = ~in_ch.ntp_seconds[31];
  assign entry.seconds  = in_ch.ntp_seconds;

  assign job_valid = (count_r != '0);
  assign job       = queue_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (job_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !job_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && job_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= entry;
    end
  end

  // Fill count stays within the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  // A lone push grows the count by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !job_pop) |=> (count_r == CW'($past(count_r) + 1'b1)))
    else $error("queue count did not grow on push");

  // The back end only pops a filled queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (count_r != '0))
    else $error("pop from empty queue");

endmodule

// ===== hdl/ntsc_back.sv =====
// Back end: multi-cycle sequencer that turns one queued item into calendar fields.
module ntsc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ntsc_pkg::job_t  job,
  input  logic            job_valid,
  output logic            job_pop,
  input  logic            cfg_we,
  input  ntsc_pkg::year_t cfg_wdata,
  ntsc_out_if.source      out_ch
);
  import ntsc_pkg::*;

  state_t      state_r, state_nxt;
  year_t       year_base_r;

  // Work registers
  secs_t       secs_r, secs_nxt;
  logic        era_r, era_nxt;
  logic [16:0] dayno_r, dayno_nxt;
  logic [16:0] tod_r, tod_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [11:0] mrem_r, mrem_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [7:0]  yq_r, yq_nxt;
  year_t       year_r, year_nxt;
  logic [8:0]  rest_r, rest_nxt;
  logic [3:0]  m_r, m_nxt;
  logic        leap_r, leap_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  yoff_r, yoff_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  dom_r, dom_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic        o_valid_res_r;
  logic [7:0]  o_yoff_r;
  logic [3:0]  o_month_r;
  logic [4:0]  o_dom_r;
  logic [4:0]  o_hour_r;
  logic [5:0]  o_min_r;
  logic [5:0]  o_sec_r;

  // Datapath
  logic [50:0] day_prod;
  logic [16:0] day_secs;
  logic [16:0] tod_raw;
  logic [16:0] tod_sum, tod_adj;
  logic        tod_carry;
  logic [26:0] hour_prod;
  logic [16:0] hour_secs, mrem_full;
  logic [20:0] min_prod;
  logic [11:0] min_secs, sec_full;
  logic [18:0] year_x;
  logic [38:0] year_prod;
  logic [18:0] year_days, yday_full;
  logic        out_load;
  logic [4:0]  mlen;
  logic        mon_done;
  year_t       ydiff;
  logic        year_low;

  // Day number and time of day; only the low 17 bits matter for the remainder
  assign day_prod = 51'(secs_r[31:7]) * 51'(DAY_RECIP);
  assign day_secs = {1'b0, dayno_r[15:0]} * SECS_PER_DAY;
  assign tod_raw  = secs_r[16:0] - day_secs;

  // Era fold: carry the time-of-day overflow into the day number
  assign tod_sum   = tod_r + ERA_SECS;
  assign tod_carry = (tod_sum >= SECS_PER_DAY);
  assign tod_adj   = tod_carry ? (tod_sum - SECS_PER_DAY) : tod_sum;

  // Hour, minute and second
  assign hour_prod = 27'(tod_r[16:4]) * 27'(HOUR_RECIP);
  assign hour_secs = {12'd0, hour_r} * SECS_PER_HOUR;
  assign mrem_full = tod_r - hour_secs;
  assign min_prod  = 21'(mrem_r[11:2]) * 21'(MIN_RECIP);
  assign min_secs  = {6'd0, min_r} * SECS_PER_MIN;
  assign sec_full  = mrem_r - min_secs;

  // Year and day of year: (dayno + 1) * 256 / 93504 is 4 * (dayno + 1) / 1461
  assign year_x    = {dayno_r + 17'd1, 2'b00};
  assign year_prod = 39'(year_x) * 39'(YEAR_RECIP);
  assign year_days = {11'd0, yq_r} * QUAD_DAYS;
  assign yday_full = year_x - year_days;

  assign mlen      = month_days(m_r, leap_r);
  assign mon_done  = (m_r == MONTHS) || (rest_r < {4'd0, mlen});

  // Year range check against the configured base
  assign year_low = (year_r < year_base_r);
  assign ydiff    = year_r - year_base_r;

  // FSM outputs
  always_comb begin
    job_pop  = (state_r == ST_IDLE) && job_valid;
    out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (job_valid) state_nxt = ST_DAY;
      ST_DAY:   state_nxt = ST_TOD;
      ST_TOD:   state_nxt = ST_ERA;
      ST_ERA:   state_nxt = ST_HOUR;
      ST_HOUR:  state_nxt = ST_MREM;
      ST_MREM:  state_nxt = ST_MIN;
      ST_MIN:   state_nxt = ST_SEC;
      ST_SEC:   state_nxt = ST_YEAR;
      ST_YEAR:  state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ST_MONTH;
      ST_MONTH: if (mon_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    secs_nxt  = secs_r;
    era_nxt   = era_r;
    dayno_nxt = dayno_r;
    tod_nxt   = tod_r;
    hour_nxt  = hour_r;
    mrem_nxt  = mrem_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    yq_nxt    = yq_r;
    year_nxt  = year_r;
    rest_nxt  = rest_r;
    m_nxt     = m_r;
    leap_nxt  = leap_r;
    valid_nxt = valid_r;
    yoff_nxt  = yoff_r;
    month_nxt = month_r;
    dom_nxt   = dom_r;
    unique case (state_r)
      ST_IDLE: begin
        secs_nxt = job.seconds;
        era_nxt  = job.next_era;
      end
      ST_DAY: begin
        dayno_nxt = {1'b0, day_prod[50:35]};
      end
      ST_TOD: begin
        tod_nxt = tod_raw;
      end
      ST_ERA: begin
        if (era_r) begin
          tod_nxt   = tod_adj;
          dayno_nxt = dayno_r + ERA_DAYS + {16'd0, tod_carry};
        end
      end
      ST_HOUR: begin
        hour_nxt = hour_prod[25:21];
      end
      ST_MREM: begin
        mrem_nxt = mrem_full[11:0];
      end
      ST_MIN: begin
        min_nxt = min_prod[19:14];
      end
      ST_SEC: begin
        sec_nxt = sec_full[5:0];
      end
      ST_YEAR: begin
        yq_nxt   = year_prod[37:30];
        year_nxt = EPOCH_YEAR + {4'd0, year_prod[37:30]};
      end
      ST_CHECK: begin
        valid_nxt = !(year_low || (ydiff[11:8] != 4'd0));
        yoff_nxt  = (year_low || (ydiff[11:8] != 4'd0)) ? 8'd0 : ydiff[7:0];
        leap_nxt  = (year_r[1:0] == 2'd0);
        rest_nxt  = yday_full[10:2];
        m_nxt     = '0;
      end
      ST_MONTH: begin
        if (m_r == MONTHS) begin
          // day past the end of the last month
          valid_nxt = 1'b0;
          month_nxt = 4'd12;
          dom_nxt   = 5'd31;
        end else if (rest_r < {4'd0, mlen}) begin
          month_nxt = m_r + 1'b1;
          dom_nxt   = rest_r[4:0] + 1'b1;
        end else begin
          rest_nxt = rest_r - {4'd0, mlen};
          m_nxt    = m_r + 1'b1;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register hand-off
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      year_base_r <= YEAR_BASE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        year_base_r <= cfg_wdata;
      end
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    secs_r  <= secs_nxt;
    era_r   <= era_nxt;
    dayno_r <= dayno_nxt;
    tod_r   <= tod_nxt;
    hour_r  <= hour_nxt;
    mrem_r  <= mrem_nxt;
    min_r   <= min_nxt;
    sec_r   <= sec_nxt;
    yq_r    <= yq_nxt;
    year_r  <= year_nxt;
    rest_r  <= rest_nxt;
    m_r     <= m_nxt;
    leap_r  <= leap_nxt;
    valid_r <= valid_nxt;
    yoff_r  <= yoff_nxt;
    month_r <= month_nxt;
    dom_r   <= dom_nxt;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_valid_res_r <= valid_r;
      o_yoff_r      <= yoff_r;
      o_month_r     <= month_r;
      o_dom_r       <= dom_r;
      o_hour_r      <= hour_r;
      o_min_r       <= min_r;
      o_sec_r       <= sec_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.valid_res    = o_valid_res_r;
  assign out_ch.year_offset  = o_yoff_r;
  assign out_ch.month        = o_month_r;
  assign out_ch.day_of_month = o_dom_r;
  assign out_ch.hour         = o_hour_r;
  assign out_ch.minute       = o_min_r;
  assign out_ch.second       = o_sec_r;

  // Folded time of day is below one day
  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOUR) |-> (tod_r < SECS_PER_DAY))
    else $error("time of day out of range");

  // Hour of day stays below 24
  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MREM) |-> (hour_r < 5'd24))
    else $error("hour out of range");

  // A finished item with a free output register shows up next cycle
  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_valid_r) |=> out_valid_r)
    else $error("finished item not loaded");

  // A valid result carries a real month and day
  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_valid_res_r) |->
      (o_month_r >= 4'd1 && o_month_r <= 4'd12 && o_dom_r >= 5'd1 && o_dom_r <= 5'd31))
    else $error("valid result with bad date");

endmodule

// ===== hdl/ntp_seconds_to_calendar.sv =====
// Top level: NTP seconds to calendar date and time converter.
//
// in_ch carries one 32-bit NTP seconds value per item (valid/ready). Bit 31
// clear means the value lies in the following era. out_ch returns one item
// per input: valid_res, year_offset from the configured base year, month,
// day_of_month, hour, minute and second. cfg_we/cfg_wdata write year_base.
//
// The front end tags each item and parks it in a small queue; the back end
// divides by constants through reciprocal multiplies, one step per cycle:
// day number, time of day, era fold, hour, seconds left in the hour, minute,
// second, year, then range check and day of year, then one month per cycle.
// The time an item takes depends on the month. The back end works on one
// item at a time and pops the next only once the last result has gone into
// the output register.
//
// Reset (rst_n low, synchronous) empties the queue, idles the sequencer,
// drops out_ch.valid and sets year_base to 2000. When the receiver stalls,
// the result waits in the output register while the next item is worked
// on; the queue keeps taking items until it fills.
module ntp_seconds_to_calendar #(
  parameter int unsigned QUEUE_DEPTH = ntsc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  ntsc_in_if.sink         in_ch,
  ntsc_out_if.source      out_ch,
  input  logic            cfg_we,
  input  ntsc_pkg::year_t cfg_wdata
);
  import ntsc_pkg::*;

  job_t job;
  logic job_valid;
  logic job_pop;

  // Accept and classify
  ntsc_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .job      (job),
    .job_valid(job_valid),
    .job_pop  (job_pop)
  );

  // Convert
  ntsc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job      (job),
    .job_valid(job_valid),
    .job_pop  (job_pop),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_ch   (out_ch)
  );

endmodule
